FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared constants and types of the slot free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int LINK_W_DEF    = $clog2(NUM_SLOTS_DEF + 1);

  // Stream field widths
  localparam int SLOT_FIELD_W = 5;
  localparam int PID_FIELD_W  = 6;
  localparam int CNT_FIELD_W  = 6;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 24;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

FILE: rtl/sfla_link_ram.sv
// ----------------------------------------------------------------------------
// sfla_link_ram
// Successor links of the free list: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfla_link_ram #(
  parameter int DEPTH  = sfla_pkg::NUM_SLOTS_DEF,
  parameter int DATA_W = sfla_pkg::LINK_W_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/slot_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_free_list_allocator_top
// LIFO free list over a pool of slots: allocate pops the head, free pushes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser
//  s_*     | in  | slot_in[4:0], zero pad to 8                | cmd
//  m_*     | out | slot_out[4:0], pid_out[10:5], free_count[16:11], pad to 24 | ok
//
//  An allocate on a non-empty list issues the link RAM read of the head in
//  its transfer cycle; in ST_EXEC the command commits the list update and loads the result.
//  After reset a sweep writes every entry of the link RAM; s_tready
//  stays low until it ends.
//  A stalled m side holds the command in its commit cycle; the next command
//  is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slot_free_list_allocator_top #(
  parameter int NUM_SLOTS = sfla_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sfla_pkg::IN_DATA_W-1:0]  s_tdata,  // slot_in
  input  logic                            s_tuser,  // cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sfla_pkg::OUT_DATA_W-1:0] m_tdata,  // slot_out, pid_out, free_count
  output logic                            m_tuser   // ok
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);
  localparam int WIDE_W = (LINK_W > sfla_pkg::PID_FIELD_W) ? LINK_W : sfla_pkg::PID_FIELD_W;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_SLOTS);

  sfla_pkg::state_t state, state_next;

  logic [SLOT_W-1:0] init_idx;
  logic [LINK_W-1:0] head, head_next;
  logic [LINK_W-1:0] free_total, count_next;
  logic              cmd_q;
  logic [sfla_pkg::SLOT_FIELD_W-1:0] slot_q;

  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data, rd_data;

  logic              load;
  logic              res_ok;
  logic [WIDE_W-1:0] res_slot, res_pid, slot_wide;
  logic              in_range, head_null, out_free, s_xfer;

  logic [sfla_pkg::SLOT_FIELD_W-1:0] out_slot;
  logic [sfla_pkg::PID_FIELD_W-1:0]  out_pid;
  logic [sfla_pkg::CNT_FIELD_W-1:0]  out_cnt;

  sfla_link_ram #(
    .DEPTH  (NUM_SLOTS),
    .DATA_W (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (head[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  assign s_tready  = (state == sfla_pkg::ST_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign head_null = (head == LINK_NULL);
  assign out_free  = !m_tvalid || m_tready;
  assign slot_wide = WIDE_W'(slot_q);
  assign in_range  = slot_wide < WIDE_W'(NUM_SLOTS);
  assign rd_en     = s_xfer && (s_tuser == sfla_pkg::CMD_ALLOC) && !head_null;

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = free_total;
    wr_en      = 1'b0;
    wr_addr    = init_idx;
    wr_data    = LINK_W'(init_idx) + LINK_W'(1);
    load       = 1'b0;
    res_ok     = 1'b0;
    res_slot   = '0;
    case (state)
      sfla_pkg::ST_INIT: begin
        wr_en = 1'b1;
        if (init_idx == SLOT_W'(NUM_SLOTS - 1)) begin
          state_next = sfla_pkg::ST_IDLE;
        end
      end
      sfla_pkg::ST_IDLE: begin
        if (s_xfer) begin
          state_next = sfla_pkg::ST_EXEC;
        end
      end
      sfla_pkg::ST_EXEC: begin
        if (cmd_q == sfla_pkg::CMD_ALLOC) begin
          if (!head_null) begin
            res_ok    = 1'b1;
            res_slot  = WIDE_W'(head);
            head_next = rd_data;
            if (free_total != '0) begin
              count_next = free_total - LINK_W'(1);
            end
          end
        end else if (in_range) begin
          res_ok    = 1'b1;
          res_slot  = slot_wide;
          head_next = LINK_W'(slot_wide);
          wr_addr   = slot_wide[SLOT_W-1:0];
          wr_data   = head;
          if (free_total < LINK_NULL) begin
            count_next = free_total + LINK_W'(1);
          end
        end
        // Hold the command until the output register can take its result
        if (out_free) begin
          load       = 1'b1;
          wr_en      = res_ok && (cmd_q == sfla_pkg::CMD_FREE);
          state_next = sfla_pkg::ST_IDLE;
        end else begin
          head_next  = head;
          count_next = free_total;
        end
      end
      default: begin
        state_next = sfla_pkg::ST_INIT;
      end
    endcase
  end

  assign res_pid = res_ok ? (res_slot + WIDE_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfla_pkg::ST_INIT;
      init_idx   <= '0;
      head       <= '0;
      free_total <= LINK_NULL;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= count_next;
      if (state == sfla_pkg::ST_INIT) begin
        init_idx <= init_idx + SLOT_W'(1);
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      cmd_q  <= s_tuser;
      slot_q <= s_tdata[sfla_pkg::SLOT_FIELD_W-1:0];
    end
    if (load) begin
      m_tuser  <= res_ok;
      out_slot <= res_slot[sfla_pkg::SLOT_FIELD_W-1:0];
      out_pid  <= res_pid[sfla_pkg::PID_FIELD_W-1:0];
      out_cnt  <= count_next[sfla_pkg::CNT_FIELD_W-1:0];
    end
  end

  assign m_tdata = {
    (sfla_pkg::OUT_DATA_W - sfla_pkg::SLOT_FIELD_W - sfla_pkg::PID_FIELD_W
      - sfla_pkg::CNT_FIELD_W)'(0),
    out_cnt, out_pid, out_slot
  };

  `ASSERT_ALWAYS(a_count_bound, free_total <= LINK_NULL, "free count above pool size")
  `ASSERT_ALWAYS(a_no_overwrite, !load || out_free, "result loaded over a waiting one")
  `ASSERT_ALWAYS(a_rw_apart, !(rd_en && wr_en), "link read and write in one cycle")
  `ASSERT_NEXT(a_xfer_exec, s_xfer, state == sfla_pkg::ST_EXEC, "command not executed after transfer")

endmodule
